/* hdl/deadline_ordered_task_release_queue_core_assert.svh */
// assertion macros for the deadline ordered release queue
// used by the checker module; needs clk and arst_n in scope
`ifndef DEADLINE_ORDERED_TASK_RELEASE_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_ORDERED_TASK_RELEASE_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DOTRQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dotrq assertion failed");

// next-cycle implication, disabled in reset
`define DOTRQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dotrq assertion failed");

`endif

/* hdl/dotrq_pkg.sv */
// shared constants for the deadline ordered release queue
// no dependencies; used by the core, the checker and the testbench
`default_nettype none

package dotrq_pkg;

	localparam int TIME_W      = 32;
	localparam int SEQ_W       = 32;
	localparam int MAX_RESULTS = 16;
	localparam int REL_CNT_W   = $clog2(MAX_RESULTS + 1);

	// request function codes
	localparam logic FUNC_SCHEDULE = 1'b0;
	localparam logic FUNC_TICK     = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_DROPPED  = 2'd1;
	localparam logic [1:0] KIND_RELEASED = 2'd2;
	localparam logic [1:0] KIND_NONE_DUE = 2'd3;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SEQ_W-1:0]  seq_t;

endpackage

`default_nettype wire

/* hdl/dotrq_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module dotrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/deadline_ordered_task_release_queue_core.sv */
// Schedule: the new task is compared with entries from the tail toward the head, each one
// that sorts after it moved back a slot, then written and accepted; an empty queue skips the walk.
// Tick: tasks due by the current time are released from the head, one result a cycle
// while the sink keeps up. One request at a time; the walk over the entry ram sets it.
// Throughput: next request taken once the sequencer is back in idle.
// Reset: asynchronous, clears count, head, sequence counter and output valid; ram not cleared.
`default_nettype none

module deadline_ordered_task_release_queue_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// request channel
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// fields low to high: current_time, task_tag, delay
	input  wire logic [((64 + TAG_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// fields: func
	input  wire logic                                   s_axis_tuser,
	// result channel
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// fields low to high: released_tag, sequence_number, due_time
	output logic      [((64 + TAG_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// fields: kind
	output logic      [1:0]                             m_axis_tuser,
	output logic                                        m_axis_tlast
);

	import dotrq_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W  = TAG_BITS + SEQ_W + TIME_W;
	localparam int DATA_W = ((64 + TAG_BITS + 7) / 8) * 8;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCMP  = 3'd1;
	localparam logic [2:0] ST_PUT   = 3'd2;
	localparam logic [2:0] ST_DROP  = 3'd3;
	localparam logic [2:0] ST_NONE  = 3'd4;
	localparam logic [2:0] ST_TCMP  = 3'd5;
	localparam logic [2:0] ST_TLAST = 3'd6;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     count_q;
	logic [PTR_W-1:0]     head_q;
	seq_t                 next_seq_q;
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     pos_q;
	logic [REL_CNT_W-1:0] rel_n_q;
	time_t                now_q;
	logic [ENT_W-1:0]     key_q;
	logic [ENT_W-1:0]     pend_q;
	logic                 out_valid_q;
	logic [ENT_W-1:0]     out_data_q;
	logic [1:0]           out_kind_q;
	logic                 out_last_q;

	logic                 ram_we;
	logic [PTR_W-1:0]     ram_waddr;
	logic [ENT_W-1:0]     ram_wdata;
	logic                 ram_re;
	logic [PTR_W-1:0]     ram_raddr;
	logic [ENT_W-1:0]     ram_rdata;

	logic                 emit;
	logic [1:0]           emit_kind;
	logic [ENT_W-1:0]     emit_data;
	logic                 emit_last;

	// circular pointer steps
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		ptr_dec = (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
	endfunction

	// request fields
	logic                in_acc;
	time_t               in_now;
	logic [TAG_BITS-1:0] in_tag;
	time_t               in_delay;
	logic [TIME_W:0]     due_sum;
	time_t               in_due;
	seq_t                seq_new;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_now        = s_axis_tdata[TIME_W-1:0];
	assign in_tag        = s_axis_tdata[TIME_W +: TAG_BITS];
	assign in_delay      = s_axis_tdata[TIME_W + TAG_BITS +: TIME_W];
	assign due_sum       = {1'b0, in_now} + {1'b0, in_delay};
	assign in_due        = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
	assign seq_new       = next_seq_q + 1'b1;

	// tail slot of the ring
	logic [PTR_W:0]   tail_sum;
	logic [PTR_W-1:0] tail_ptr;
	logic             q_full;

	assign tail_sum = {1'b0, head_q} + (PTR_W + 1)'(count_q);
	assign tail_ptr = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
		PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
	assign q_full   = (count_q == CNT_W'(QUEUE_DEPTH));

	// entry fields: tag low, then sequence, then deadline
	time_t rd_due;
	seq_t  rd_seq;
	time_t key_due;
	seq_t  key_seq;
	logic  s_before;
	logic  t_due;
	logic  more;
	logic  out_free;

	assign rd_due   = ram_rdata[TAG_BITS + SEQ_W +: TIME_W];
	assign rd_seq   = ram_rdata[TAG_BITS +: SEQ_W];
	assign key_due  = key_q[TAG_BITS + SEQ_W +: TIME_W];
	assign key_seq  = key_q[TAG_BITS +: SEQ_W];
	assign s_before = (rd_due < key_due) || ((rd_due == key_due) && (rd_seq < key_seq));
	assign t_due    = (rd_due <= now_q);
	assign more     = (count_q != CNT_W'(1)) && (rel_n_q != REL_CNT_W'(MAX_RESULTS - 1));
	assign out_free = !out_valid_q || m_axis_tready;

	// ram access and result selection per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_wdata = key_q;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		emit      = 1'b0;
		emit_kind = KIND_RELEASED;
		emit_data = pend_q;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_axis_tuser == FUNC_TICK) begin
						ram_re = (count_q != '0);
					end else begin
						ram_re    = !q_full && (count_q != '0);
						ram_raddr = ptr_dec(tail_ptr);
					end
				end
			end
			ST_SCMP: begin
				if (!s_before) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					ram_re    = (pos_q != CNT_W'(1));
					ram_raddr = ptr_dec(rd_ptr_q);
				end
			end
			ST_PUT: begin
				if (out_free) begin
					ram_we    = 1'b1;
					emit      = 1'b1;
					emit_kind = KIND_ACCEPTED;
					emit_data = key_q;
				end
			end
			ST_DROP: begin
				emit      = out_free;
				emit_kind = KIND_DROPPED;
				emit_data = {key_due, {SEQ_W{1'b0}}, key_q[TAG_BITS-1:0]};
			end
			ST_NONE: begin
				emit      = out_free;
				emit_kind = KIND_NONE_DUE;
				emit_data = '0;
			end
			ST_TCMP: begin
				ram_raddr = ptr_inc(head_q);
				if (rel_n_q == '0) begin
					ram_re = t_due && more;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_last = !t_due;
					ram_re    = t_due && more;
				end
			end
			ST_TLAST: begin
				emit = out_free;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			head_q     <= '0;
			next_seq_q <= '0;
			rel_n_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rel_n_q <= '0;
						if (s_axis_tuser == FUNC_TICK) begin
							state_q <= (count_q == '0) ? ST_NONE : ST_TCMP;
						end else if (q_full) begin
							state_q <= ST_DROP;
						end else begin
							next_seq_q <= seq_new;
							state_q    <= (count_q == '0) ? ST_PUT : ST_SCMP;
						end
					end
				end
				ST_SCMP: begin
					if (s_before || (pos_q == CNT_W'(1))) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DROP, ST_NONE, ST_TLAST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TCMP: begin
					if ((rel_n_q == '0) || out_free) begin
						if (t_due) begin
							head_q  <= ptr_inc(head_q);
							count_q <= count_q - 1'b1;
							rel_n_q <= rel_n_q + 1'b1;
							state_q <= more ? ST_TCMP : ST_TLAST;
						end else begin
							state_q <= (rel_n_q == '0) ? ST_NONE : ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q    <= in_now;
			key_q    <= {in_due, seq_new, in_tag};
			wr_ptr_q <= tail_ptr;
			rd_ptr_q <= ptr_dec(tail_ptr);
			pos_q    <= count_q;
		end
		if ((state_q == ST_SCMP) && !s_before) begin
			wr_ptr_q <= rd_ptr_q;
			rd_ptr_q <= ptr_dec(rd_ptr_q);
			pos_q    <= pos_q - 1'b1;
		end
		if ((state_q == ST_TCMP) && t_due && ((rel_n_q == '0) || out_free)) begin
			pend_q <= ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_data;
			out_kind_q <= emit_kind;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'(out_data_q);
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// entry store, ring ordered from head
	dotrq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire

/* hdl/dotrq_chk.sv */
// port level checker for the deadline ordered release queue, with its bind
// depends on dotrq_pkg and the assertion macro header
`default_nettype none
`include "deadline_ordered_task_release_queue_core_assert.svh"

module dotrq_chk #(
	parameter int TAG_BITS = 16
) (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   s_axis_tvalid,
	input wire logic                                   s_axis_tready,
	input wire logic                                   m_axis_tvalid,
	input wire logic                                   m_axis_tready,
	input wire logic [((64 + TAG_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input wire logic [1:0]                             m_axis_tuser,
	input wire logic                                   m_axis_tlast
);

	import dotrq_pkg::*;

	// a stalled result holds still
	`DOTRQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// one request in flight at a time
	`DOTRQ_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// only a released task can be followed by more results
	`DOTRQ_ASSERT_NOW(a_single_last, m_axis_tvalid && (m_axis_tuser != KIND_RELEASED), m_axis_tlast)

	// nothing due carries no task
	`DOTRQ_ASSERT_NOW(a_none_zero, m_axis_tvalid && (m_axis_tuser == KIND_NONE_DUE), m_axis_tdata == '0)

	// dropped task gets no sequence number
	`DOTRQ_ASSERT_NOW(a_drop_seq, m_axis_tvalid && (m_axis_tuser == KIND_DROPPED), m_axis_tdata[TAG_BITS +: SEQ_W] == '0)

endmodule

bind deadline_ordered_task_release_queue_core dotrq_chk #(
	.TAG_BITS(TAG_BITS)
) u_dotrq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

/* tb/tb_deadline_ordered_task_release_queue_core.sv */
// self-checking testbench for the deadline ordered task release queue core
// depends on dotrq_pkg and deadline_ordered_task_release_queue_core; predicts the
// sorted queue in step with each accepted request and checks every result
`timescale 1ns / 100ps

module tb_deadline_ordered_task_release_queue_core;

	import dotrq_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int TAG_W        = 16;
	localparam int DATA_W       = ((64 + TAG_W + 7) / 8) * 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_REQS  = 325;

	typedef struct packed {
		logic             func;
		time_t            now;
		logic [TAG_W-1:0] tag;
		time_t            delay;
	} queue_request_t;

	typedef struct packed {
		time_t            due;
		seq_t             seq;
		logic [TAG_W-1:0] tag;
	} queued_task_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [TAG_W-1:0] tag;
		seq_t             seq;
		time_t            due;
		logic             last;
	} queue_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic [1:0]        m_axis_tuser;
	logic              m_axis_tlast;

	queue_request_t request_backlog[$];
	queue_request_t request_on_bus;
	queued_task_t   model_tasks[$];
	queue_result_t  expected_results[$];
	seq_t           model_next_seq = '0;

	int requests_taken = 0;
	int fault_count = 0;
	int idle_cycles = 0;
	int seen_accepted = 0;
	int seen_dropped = 0;
	int seen_released = 0;
	int seen_none_due = 0;
	logic steady_stretch;

	deadline_ordered_task_release_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TAG_BITS   (TAG_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// no idling on either side while this window of requests goes through
	assign steady_stretch = (requests_taken >= 150) && (requests_taken < 230);

	function automatic void add_request(logic func, time_t now, logic [TAG_W-1:0] tag,
			time_t delay);
		request_backlog.insert(request_backlog.size(), '{func, now, tag, delay});
	endfunction

	// appends one result to the expected list
	function automatic void expect_result(queue_result_t res);
		expected_results.insert(expected_results.size(), res);
	endfunction

	// updates the sorted task list for one request and queues the results it causes
	function void predict_release_queue(queue_request_t req);
		logic [32:0] sum;
		time_t       due;
		int          pos;
		int          due_count;
		if (req.func == FUNC_SCHEDULE) begin
			sum = {1'b0, req.now} + {1'b0, req.delay};
			due = sum[32] ? '1 : sum[31:0];
			if (model_tasks.size() >= QUEUE_DEPTH) begin
				expect_result('{KIND_DROPPED, req.tag, '0, due, 1'b1});
			end else begin
				model_next_seq = model_next_seq + 1'b1;
				pos = 0;
				// deadline first, sequence number breaks ties
				while (pos < model_tasks.size() && (model_tasks[pos].due < due ||
						(model_tasks[pos].due == due && model_tasks[pos].seq < model_next_seq)))
					pos++;
				model_tasks.insert(pos, '{due, model_next_seq, req.tag});
				expect_result('{KIND_ACCEPTED, req.tag, model_next_seq, due, 1'b1});
			end
		end else begin
			due_count = 0;
			while (due_count < model_tasks.size() && due_count < MAX_RESULTS &&
					model_tasks[due_count].due <= req.now)
				due_count++;
			if (due_count == 0) begin
				expect_result('{KIND_NONE_DUE, '0, '0, '0, 1'b1});
			end else begin
				for (int i = 0; i < due_count; i++) begin
					expect_result('{KIND_RELEASED, model_tasks[0].tag,
						model_tasks[0].seq, model_tasks[0].due, logic'(i == due_count - 1)});
					void'(model_tasks.pop_front());
				end
			end
		end
	endfunction

	// request driver: predicts on acceptance, then offers the next pending request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_release_queue(request_on_bus);
				requests_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (request_backlog.size() != 0 &&
						(steady_stretch || $urandom_range(99) >= 26)) begin
					request_on_bus = request_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {request_on_bus.delay, request_on_bus.tag,
						request_on_bus.now};
					s_axis_tuser  <= request_on_bus.func;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady_stretch || ($urandom_range(99) >= 26);
		end
	end

	// result monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		queue_result_t got;
		queue_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
				m_axis_tdata[79:48], m_axis_tlast};
			case (got.kind)
				KIND_ACCEPTED: seen_accepted++;
				KIND_DROPPED:  seen_dropped++;
				KIND_RELEASED: seen_released++;
				KIND_NONE_DUE: seen_none_due++;
				default: ;
			endcase
			if (expected_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected result kind %0d tag %h seq %0d due %h last %b",
						$realtime, got.kind, got.tag, got.seq, got.due, got.last);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("%0t: result mismatch", $realtime);
						$display("  expected kind %0d tag %h seq %0d due %h last %b",
							want.kind, want.tag, want.seq, want.due, want.last);
						$display("  actual   kind %0d tag %h seq %0d due %h last %b",
							got.kind, got.tag, got.seq, got.due, got.last);
					end
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("tb_deadline_ordered_task_release_queue_core failed");
				$finish;
			end
		end
	end

	initial begin
		time_t clock_now;
		int    pick;
		int    burst;
		int    random_target;

		// directed: nothing due, tag extremes, ties, saturation
		add_request(FUNC_TICK, 32'd0, 16'h0000, 32'd0);
		add_request(FUNC_SCHEDULE, 32'd0, 16'hFFFF, 32'd0);
		add_request(FUNC_SCHEDULE, 32'd5, 16'h0000, 32'd10);
		add_request(FUNC_SCHEDULE, 32'd10, 16'hA5A5, 32'd5);
		add_request(FUNC_SCHEDULE, 32'hFFFF_FFF0, 16'h5A5A, 32'hFFFF_FFFF);
		add_request(FUNC_SCHEDULE, 32'hFFFF_FFFF, 16'h1234, 32'd0);
		add_request(FUNC_TICK, 32'd14, 16'hFFFF, 32'hFFFF_FFFF);
		add_request(FUNC_TICK, 32'd15, 16'h0000, 32'd0);
		add_request(FUNC_TICK, 32'hFFFF_FFFE, 16'h0000, 32'd0);
		// fill to capacity, each new task landing at the front
		for (int i = 0; i < QUEUE_DEPTH - 2; i++)
			add_request(FUNC_SCHEDULE, 32'd100, 16'(i * 16'h1111), 32'(70 - 5 * i));
		// full queue drops, then one tick releases the whole queue
		add_request(FUNC_SCHEDULE, 32'd200, 16'hBEEF, 32'd1);
		add_request(FUNC_TICK, 32'hFFFF_FFFF, 16'h0000, 32'd0);

		// random: mostly bursts of schedules followed by a tick, with some noise
		random_target = request_backlog.size() + RANDOM_REQS;
		clock_now = '0;
		while (request_backlog.size() < random_target) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				burst = $urandom_range(1, 18);
				repeat (burst) begin
					clock_now += $urandom_range(0, 3);
					add_request(FUNC_SCHEDULE, clock_now, 16'($urandom),
						32'($urandom_range(0, 24)));
				end
				clock_now += $urandom_range(0, 30);
				add_request(FUNC_TICK, clock_now, 16'($urandom), $urandom);
			end else if (pick < 80) begin
				add_request(1'($urandom_range(1)), $urandom, 16'($urandom), $urandom);
			end else if (pick < 90) begin
				add_request(FUNC_SCHEDULE, clock_now, 16'($urandom), $urandom);
			end else if (pick < 95) begin
				add_request(FUNC_TICK, 32'hFFFF_FFFF, 16'($urandom), $urandom);
			end else begin
				clock_now = $urandom;
				add_request(FUNC_TICK, clock_now, 16'($urandom), $urandom);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fault_count += expected_results.size();

		$display("covered %0d requests: %0d tasks accepted, %0d dropped on a full queue",
			requests_taken, seen_accepted, seen_dropped);
		$display("  %0d tasks released, %0d ticks with nothing due, %0d faults",
			seen_released, seen_none_due, fault_count);
		if (fault_count == 0)
			$display("tb_deadline_ordered_task_release_queue_core passed");
		else
			$display("tb_deadline_ordered_task_release_queue_core failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/dotrq_pkg.sv
hdl/dotrq_ram.sv
hdl/deadline_ordered_task_release_queue_core.sv
hdl/dotrq_chk.sv
tb/tb_deadline_ordered_task_release_queue_core.sv
